/* rtl/core/lfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame line cache package
// Shared request and status codes, FSM states, line marks and the tag width of a line entry.
// ----------------------------------------------------------------------------
package lfc_pkg;

  typedef enum logic [1:0] {
    REQ_FRAME   = 2'd0,
    REQ_DONE    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_FULL     = 3'd2,
    ST_DONE_OK  = 3'd3,
    ST_DONE_BAD = 3'd4,
    ST_RELEASED = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SINGLE_RD,
    S_SINGLE_WR,
    S_FILL,
    S_OUT
  } state_t;

  localparam int unsigned NUM_LINES = 64;

  localparam logic [2:0] MARK_DECODING = 3'd1;
  localparam logic [2:0] MARK_INUSE    = 3'd2;
  localparam logic [2:0] MARK_VALID    = 3'd4;

  localparam logic [6:0] LIMIT_RESET = 7'd48;

  localparam int unsigned TAG_BITS = 16 + 15 + 15 + 8 + 32;

endpackage : lfc_pkg
`default_nettype wire

/* rtl/core/lfc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module lfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : lfc_ram
`default_nettype wire

/* rtl/core/lru_frame_line_cache.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame line cache
// Fully associative line cache tagged by file, size, format and frame, with
// least-recently-used eviction and reference-count pinning.
// ----------------------------------------------------------------------------
// Usage: items enter on the valid/ready input channel and each produces one
// result item on the valid/ready output channel. Line state (tag, marks,
// count, last-use time) sits in one synchronous RAM; presence bits are
// flip-flops cleared at reset.
// A frame request or a clear sweeps every line through the RAM port, one
// line read per cycle. Decode-done and release items read one line and
// rewrite it if present. A clear writes nothing to the RAM; it drops
// presence bits during the sweep. One item is in work at a time. The
// result sits in an output register and the input stays not ready until
// that result is taken, so a stalled receiver holds the block. Reset
// empties the cache, zeroes both counters and sets line_limit to 48; the
// RAM contents are left as they are. The user must write line_limit at
// APB port address 0 only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lru_frame_line_cache #(
  parameter int unsigned REF_BITS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] file_id,
  input  wire logic [14:0] frame_width,
  input  wire logic [14:0] frame_height,
  input  wire logic [7:0]  pixel_format,
  input  wire logic [31:0] frame_number,
  input  wire logic [5:0]  line_index,
  input  wire logic        decode_ok,
  input  wire logic        clear_all,
  input  wire logic [31:0] now_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [5:0]       line_out,
  output logic [31:0]      hits,
  output logic [31:0]      misses,
  output logic [6:0]       lines_used
);
  import lfc_pkg::*;

  localparam int unsigned IW  = $clog2(NUM_LINES);
  localparam int unsigned CW  = $clog2(NUM_LINES + 1);
  localparam int unsigned EW  = TAG_BITS + 3 + REF_BITS + 32;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  typedef struct packed {
    logic [15:0]         file;
    logic [14:0]         width;
    logic [14:0]         height;
    logic [7:0]          format;
    logic [31:0]         frame;
    logic [2:0]          marks;
    logic [REF_BITS-1:0] refs;
    logic [31:0]         last;
  } entry_t;

  state_t state, state_next;

  logic [6:0]  line_limit;
  logic [NUM_LINES-1:0] present;
  logic [CW-1:0] used;
  logic [31:0] hit_counter, miss_counter;

  req_t        r_type;
  logic [15:0] r_file;
  logic [14:0] r_width, r_height;
  logic [7:0]  r_format;
  logic [31:0] r_frame, r_now;
  logic [5:0]  r_index;
  logic        r_ok, r_all;

  logic [IW-1:0] scan_addr;
  logic          scan_rd;
  logic [IW-1:0] scan_cur;
  logic          scan_last;

  logic          hit_found, free_found, bare_found, old_found;
  logic [IW-1:0] hit_line, free_line, bare_line, old_line;
  logic [31:0]   old_time;
  entry_t        hit_entry;

  logic          ram_we;
  logic [IW-1:0] ram_addr;
  entry_t        ram_wdata, ram_rdata;

  logic [2:0]  res_status;
  logic [5:0]  res_line;

  logic [6:0]  limit_eff;
  logic        here;
  logic [IW-1:0] lx;

  lfc_ram #(.WIDTH(EW), .DEPTH(NUM_LINES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = {25'd0, line_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && !paddr) begin
      line_limit <= pwdata[6:0];
    end
  end

  assign limit_eff = (32'(line_limit) < NUM_LINES) ? line_limit : 7'(NUM_LINES);
  assign lx   = IW'(r_index);
  assign here = (32'(r_index) < NUM_LINES) && present[lx];

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign status = res_status;
  assign line_out = res_line;
  assign hits = hit_counter;
  assign misses = miss_counter;
  assign lines_used = 7'(used);

  // Scan compare on the line read in the previous cycle.
  logic cur_present, cur_match, cur_idle;
  always_comb begin
    cur_present = present[scan_cur];
    cur_match = cur_present && ram_rdata.file == r_file && ram_rdata.width == r_width &&
                ram_rdata.height == r_height && ram_rdata.format == r_format &&
                ram_rdata.frame == r_frame && ram_rdata.marks[2];
    cur_idle = cur_present && ram_rdata.marks[1:0] == 2'b00;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_t'(req_type) == REQ_FRAME || req_t'(req_type) == REQ_CLEAR) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_SINGLE_RD;
          end
        end
      end
      S_SCAN: if (scan_rd && scan_last) state_next = S_FILL;
      S_SINGLE_RD: state_next = S_SINGLE_WR;
      S_SINGLE_WR: state_next = S_OUT;
      S_FILL: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Chosen line for a miss.
  logic          take_ok;
  logic [IW-1:0] take_line;
  always_comb begin
    take_ok = 1'b1;
    take_line = '0;
    if (7'(used) < limit_eff && free_found) begin
      take_line = free_line;
    end else if (bare_found) begin
      take_line = bare_line;
    end else if (old_found) begin
      take_line = old_line;
    end else begin
      take_ok = 1'b0;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = scan_addr;
    ram_wdata = ram_rdata;
    unique case (state)
      S_IDLE: ram_addr = IW'(line_index);
      S_SINGLE_RD: ram_addr = lx;
      S_SINGLE_WR: begin
        ram_addr = lx;
        ram_we = here && (r_type == REQ_DONE || r_type == REQ_RELEASE);
        if (r_type == REQ_DONE) begin
          ram_wdata.refs = (ram_rdata.refs == REF_MAX) ? REF_MAX : ram_rdata.refs + 1'b1;
          if (r_ok) begin
            ram_wdata.marks = (ram_rdata.marks | MARK_VALID | MARK_INUSE) & ~MARK_DECODING;
            ram_wdata.last = r_now;
          end else begin
            ram_wdata.marks = (ram_rdata.marks & ~(MARK_VALID | MARK_DECODING)) | MARK_INUSE;
          end
        end else begin
          ram_wdata.refs = (ram_rdata.refs == '0) ? '0 : ram_rdata.refs - 1'b1;
          if (ram_wdata.refs == '0) ram_wdata.marks = ram_rdata.marks & ~MARK_INUSE;
        end
      end
      S_FILL: begin
        ram_wdata = hit_entry;
        if (r_type == REQ_FRAME) begin
          if (hit_found) begin
            ram_addr = hit_line;
            ram_we = 1'b1;
            ram_wdata.refs = (hit_entry.refs == REF_MAX) ? REF_MAX : hit_entry.refs + 1'b1;
            ram_wdata.marks = hit_entry.marks | MARK_INUSE;
            ram_wdata.last = r_now;
          end else if (take_ok) begin
            ram_addr = take_line;
            ram_we = 1'b1;
            ram_wdata = '{file: r_file, width: r_width, height: r_height, format: r_format,
                          frame: r_frame, marks: MARK_DECODING, refs: '0, last: '0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      present <= '0;
      used <= '0;
      hit_counter <= '0;
      miss_counter <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN && scan_rd && r_type == REQ_CLEAR && cur_idle &&
          (r_all || ram_rdata.file == r_file)) begin
        present[scan_cur] <= 1'b0;
        used <= used - 1'b1;
      end
      if (state == S_SINGLE_WR && here && r_type == REQ_DONE && r_ok) begin
        miss_counter <= miss_counter + 1'b1;
      end
      if (state == S_FILL) begin
        if (r_type == REQ_CLEAR) begin
          hit_counter <= '0;
          miss_counter <= '0;
        end else if (hit_found) begin
          hit_counter <= hit_counter + 1'b1;
        end else if (take_ok && !present[take_line]) begin
          present[take_line] <= 1'b1;
          used <= used + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      r_type <= req_t'(req_type);
      r_file <= file_id;
      r_width <= frame_width;
      r_height <= frame_height;
      r_format <= pixel_format;
      r_frame <= frame_number;
      r_now <= now_time;
      r_index <= line_index;
      r_ok <= decode_ok;
      r_all <= clear_all;
      scan_addr <= '0;
      scan_rd <= 1'b0;
      scan_last <= 1'b0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
      bare_found <= 1'b0;
      old_found <= 1'b0;
    end
    if (state == S_SCAN) begin
      scan_cur <= scan_addr;
      scan_rd <= 1'b1;
      scan_last <= (32'(scan_addr) == NUM_LINES - 1);
      if (32'(scan_addr) != NUM_LINES - 1) scan_addr <= scan_addr + 1'b1;
      if (scan_rd) begin
        if (cur_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_line <= scan_cur;
          hit_entry <= ram_rdata;
        end
        if (!cur_present && !free_found) begin
          free_found <= 1'b1;
          free_line <= scan_cur;
        end
        if (cur_present && ram_rdata.marks == 3'd0 && !bare_found) begin
          bare_found <= 1'b1;
          bare_line <= scan_cur;
        end
        if (cur_idle && ram_rdata.last <= r_now &&
            (!old_found || ram_rdata.last < old_time)) begin
          old_found <= 1'b1;
          old_line <= scan_cur;
          old_time <= ram_rdata.last;
        end
      end
    end
    if (state == S_SINGLE_WR) begin
      res_line <= r_index;
      if (r_type == REQ_DONE) begin
        res_status <= (here && r_ok) ? ST_DONE_OK : ST_DONE_BAD;
      end else begin
        res_status <= ST_RELEASED;
      end
    end
    if (state == S_FILL) begin
      if (r_type == REQ_CLEAR) begin
        res_status <= ST_CLEARED;
        res_line <= '0;
      end else if (hit_found) begin
        res_status <= ST_HIT;
        res_line <= 6'(hit_line);
      end else if (take_ok) begin
        res_status <= ST_MISS;
        res_line <= 6'(take_line);
      end else begin
        res_status <= ST_FULL;
        res_line <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used) <= NUM_LINES) else $error("line count above capacity");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_fill_to_out: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |=> out_valid) else $error("scan did not yield a result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
`endif

endmodule : lru_frame_line_cache
`default_nettype wire
